// ===== src/framed_packet_parser_assert.svh =====
// Assertion macros shared by the parser modules.
// Each check is sampled on the rising clock edge and is off while reset is low.
`ifndef FRAMED_PACKET_PARSER_ASSERT_SVH
`define FRAMED_PACKET_PARSER_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define FPP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framed packet parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define FPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framed packet parser check failed");

`else

`define FPP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FPP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/fpp_pkg.sv =====
package fpp_pkg;

    // Default depth of the payload buffer.
    localparam int FPP_MAX_PAYLOAD = 32;

    // Configuration register indexes.
    localparam logic [2:0] REG_HEADER_BYTE     = 3'd0;
    localparam logic [2:0] REG_TAIL_BYTE       = 3'd1;
    localparam logic [2:0] REG_MAX_LENGTH      = 3'd2;
    localparam logic [2:0] REG_PARSE_ENABLE    = 3'd3;
    localparam logic [2:0] REG_CHECKSUM_ENABLE = 3'd4;

    // Configuration reset values.
    localparam logic [7:0] RST_HEADER_BYTE = 8'hAA;
    localparam logic [7:0] RST_TAIL_BYTE   = 8'h55;
    localparam logic [5:0] RST_MAX_LENGTH  = 6'd32;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BAD_SUM = 2'd2,
        ST_NO_TAIL = 2'd3
    } status_t;

    // One finished frame handed from the parser to the emitter.
    typedef struct packed {
        status_t     status;
        logic [7:0]  cmd;
        logic [5:0]  length;
    } job_t;

    // Readiness of the emitter as seen by the parser side.
    typedef struct packed {
        logic ram_free;   // buffer is not being read
        logic job_ready;  // a new frame may be handed over
    } emit_status_t;

    // Address width of a buffer of the given depth.
    function automatic int addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== src/fpp_ram.sv =====
module fpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fpp_pkg::FPP_MAX_PAYLOAD
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [fpp_pkg::addr_width(DEPTH)-1:0]     wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [fpp_pkg::addr_width(DEPTH)-1:0]     rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/fpp_parser.sv =====
`include "framed_packet_parser_assert.svh"

module fpp_parser #(
    parameter int MAX_PAYLOAD = fpp_pkg::FPP_MAX_PAYLOAD
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // Configuration writes
    input  logic                                         cfg_we,
    input  logic [2:0]                                   cfg_addr,
    input  logic [7:0]                                   cfg_data,
    // Accepted received byte
    input  logic                                         byte_valid,
    input  logic [7:0]                                   byte_data,
    output logic                                         at_tail,
    // Payload buffer write port
    output logic                                         ram_wr_en,
    output logic [fpp_pkg::addr_width(MAX_PAYLOAD)-1:0]  ram_wr_addr,
    output logic [7:0]                                   ram_wr_data,
    // Finished frame
    output logic                                         job_valid,
    output fpp_pkg::job_t                                job
);

    localparam int         AW      = fpp_pkg::addr_width(MAX_PAYLOAD);
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_CHECK,
        PH_TAIL
    } phase_t;

    phase_t         phase_reg, phase_next;
    logic [7:0]     cmd_reg, cmd_next;
    logic [5:0]     len_reg, len_next;
    logic [5:0]     fill_reg, fill_next;
    logic [7:0]     xor_reg, xor_next;
    logic           good_reg, good_next;
    logic           job_valid_reg, job_valid_next;
    fpp_pkg::job_t  job_reg, job_next;

    logic [7:0]     header_reg;
    logic [7:0]     tail_reg;
    logic [5:0]     max_len_reg;
    logic           parse_en_reg;
    logic           sum_en_reg;

    logic           step;
    logic [5:0]     fill_inc;

    assign step     = byte_valid && parse_en_reg;
    assign fill_inc = fill_reg + 6'd1;

    // Phase sequencing on each accepted byte.
    always_comb begin
        phase_next     = phase_reg;
        cmd_next       = cmd_reg;
        len_next       = len_reg;
        fill_next      = fill_reg;
        xor_next       = xor_reg;
        good_next      = good_reg;
        job_valid_next = 1'b0;
        job_next       = job_reg;
        if (step) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (byte_data == header_reg) begin
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD: begin
                    cmd_next   = byte_data;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    if ((byte_data > {2'b00, max_len_reg}) || (byte_data > MAX_LEN)) begin
                        phase_next = PH_IDLE;
                    end else begin
                        len_next  = byte_data[5:0];
                        fill_next = 6'd0;
                        xor_next  = cmd_reg ^ byte_data;
                        good_next = 1'b0;
                        if (byte_data == 8'd0) begin
                            if (sum_en_reg) begin
                                phase_next = PH_CHECK;
                            end else begin
                                good_next  = 1'b1;
                                phase_next = PH_TAIL;
                            end
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    xor_next  = xor_reg ^ byte_data;
                    fill_next = fill_inc;
                    if (fill_inc >= len_reg) begin
                        if (sum_en_reg) begin
                            phase_next = PH_CHECK;
                        end else begin
                            good_next  = 1'b1;
                            phase_next = PH_TAIL;
                        end
                    end
                end
                PH_CHECK: begin
                    good_next  = (byte_data == xor_reg);
                    phase_next = PH_TAIL;
                end
                PH_TAIL: begin
                    job_valid_next = 1'b1;
                    job_next.cmd    = cmd_reg;
                    job_next.length = len_reg;
                    if (byte_data != tail_reg) begin
                        job_next.status = fpp_pkg::ST_NO_TAIL;
                    end else if (!good_reg) begin
                        job_next.status = fpp_pkg::ST_BAD_SUM;
                    end else if (len_reg == 6'd0) begin
                        job_next.status = fpp_pkg::ST_EMPTY;
                    end else begin
                        job_next.status = fpp_pkg::ST_PAYLOAD;
                    end
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // State, frame fields and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            cmd_reg       <= 8'd0;
            len_reg       <= 6'd0;
            fill_reg      <= 6'd0;
            xor_reg       <= 8'd0;
            good_reg      <= 1'b0;
            job_valid_reg <= 1'b0;
            header_reg    <= fpp_pkg::RST_HEADER_BYTE;
            tail_reg      <= fpp_pkg::RST_TAIL_BYTE;
            max_len_reg   <= fpp_pkg::RST_MAX_LENGTH;
            parse_en_reg  <= 1'b1;
            sum_en_reg    <= 1'b1;
        end else begin
            phase_reg     <= phase_next;
            cmd_reg       <= cmd_next;
            len_reg       <= len_next;
            fill_reg      <= fill_next;
            xor_reg       <= xor_next;
            good_reg      <= good_next;
            job_valid_reg <= job_valid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    fpp_pkg::REG_HEADER_BYTE:     header_reg   <= cfg_data;
                    fpp_pkg::REG_TAIL_BYTE:       tail_reg     <= cfg_data;
                    fpp_pkg::REG_MAX_LENGTH:      max_len_reg  <= cfg_data[5:0];
                    fpp_pkg::REG_PARSE_ENABLE:    parse_en_reg <= cfg_data[0];
                    fpp_pkg::REG_CHECKSUM_ENABLE: sum_en_reg   <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Job payload needs no reset.
    always_ff @(posedge aclk) begin
        job_reg <= job_next;
    end

    // Payload bytes go straight into the buffer.
    assign ram_wr_en   = step && (phase_reg == PH_DATA);
    assign ram_wr_addr = fill_reg[AW-1:0];
    assign ram_wr_data = byte_data;

    assign at_tail   = (phase_reg == PH_TAIL);
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    // A payload fill never reaches the stored length.
    `FPP_ASSERT_SAME(a_fill_below_len, aclk, aresetn,
        phase_reg == PH_DATA, fill_reg < len_reg)
    // A frame in the payload phase has a length the buffer can hold.
    `FPP_ASSERT_SAME(a_len_in_range, aclk, aresetn,
        phase_reg == PH_DATA, (len_reg != 6'd0) && ({2'b00, len_reg} <= MAX_LEN))
    // A finished frame always returns the parser to header hunting.
    `FPP_ASSERT_NEXT(a_tail_to_idle, aclk, aresetn,
        step && (phase_reg == PH_TAIL), (phase_reg == PH_IDLE) && job_valid_reg)

endmodule

// ===== src/fpp_emitter.sv =====
`include "framed_packet_parser_assert.svh"

module fpp_emitter #(
    parameter int MAX_PAYLOAD = fpp_pkg::FPP_MAX_PAYLOAD
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // Finished frame from the parser
    input  logic                                         job_valid,
    input  fpp_pkg::job_t                                job,
    output fpp_pkg::emit_status_t                        emit_status,
    // Payload buffer read port
    output logic                                         ram_rd_en,
    output logic [fpp_pkg::addr_width(MAX_PAYLOAD)-1:0]  ram_rd_addr,
    input  logic [7:0]                                   ram_rd_data,
    // Result item
    output logic                                         res_valid,
    input  logic                                         res_ready,
    output fpp_pkg::status_t                             res_status,
    output logic [7:0]                                   res_cmd,
    output logic [5:0]                                   res_length,
    output logic [4:0]                                   res_index,
    output logic [7:0]                                   res_payload,
    output logic                                         res_last
);

    localparam int AW = fpp_pkg::addr_width(MAX_PAYLOAD);

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_FETCH,
        EM_LOAD,
        EM_SHOW
    } em_state_t;

    em_state_t         state_reg;
    logic [5:0]        idx_reg;
    logic              valid_reg;
    fpp_pkg::status_t  status_reg;
    logic [7:0]        cmd_reg;
    logic [5:0]        len_reg;
    logic [4:0]        index_reg;
    logic [7:0]        payload_reg;
    logic              last_reg;

    // Sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EM_IDLE;
            valid_reg <= 1'b0;
            idx_reg   <= 6'd0;
            last_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                EM_IDLE: begin
                    if (job_valid) begin
                        cmd_reg <= job.cmd;
                        len_reg <= job.length;
                        idx_reg <= 6'd0;
                        if (job.status == fpp_pkg::ST_PAYLOAD) begin
                            state_reg <= EM_FETCH;
                        end else begin
                            status_reg  <= job.status;
                            index_reg   <= 5'd0;
                            payload_reg <= 8'd0;
                            last_reg    <= 1'b1;
                            valid_reg   <= 1'b1;
                            state_reg   <= EM_SHOW;
                        end
                    end
                end
                EM_FETCH: begin
                    state_reg <= EM_LOAD;
                end
                EM_LOAD: begin
                    status_reg  <= fpp_pkg::ST_PAYLOAD;
                    index_reg   <= idx_reg[4:0];
                    payload_reg <= ram_rd_data;
                    last_reg    <= ((idx_reg + 6'd1) == len_reg);
                    valid_reg   <= 1'b1;
                    state_reg   <= EM_SHOW;
                end
                EM_SHOW: begin
                    if (res_ready) begin
                        valid_reg <= 1'b0;
                        if (last_reg) begin
                            state_reg <= EM_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 6'd1;
                            state_reg <= EM_FETCH;
                        end
                    end
                end
                default: begin
                    state_reg <= EM_IDLE;
                end
            endcase
        end
    end

    // The buffer is read in the fetch state, the cycle before the output load.
    assign ram_rd_en   = (state_reg == EM_FETCH);
    assign ram_rd_addr = idx_reg[AW-1:0];

    // The buffer is free once the final result of a run is loaded.
    assign emit_status.ram_free  = (state_reg == EM_IDLE) ||
                                   ((state_reg == EM_SHOW) && last_reg);
    assign emit_status.job_ready = (state_reg == EM_IDLE);

    assign res_valid   = valid_reg;
    assign res_status  = status_reg;
    assign res_cmd     = cmd_reg;
    assign res_length  = len_reg;
    assign res_index   = index_reg;
    assign res_payload = payload_reg;
    assign res_last    = last_reg;

    // A new frame only arrives while no run is in progress.
    `FPP_ASSERT_SAME(a_job_when_idle, aclk, aresetn,
        job_valid, state_reg == EM_IDLE)
    // The output register is full exactly in the show state.
    `FPP_ASSERT_SAME(a_valid_in_show, aclk, aresetn,
        valid_reg, state_reg == EM_SHOW)
    // Error and empty results stand alone as the last of their run.
    `FPP_ASSERT_SAME(a_error_is_last, aclk, aresetn,
        valid_reg && (status_reg != fpp_pkg::ST_PAYLOAD),
        last_reg && (index_reg == 5'd0) && (payload_reg == 8'd0))
    // Buffer data moves from the read register into the output register as the load state gives way to show.
    `FPP_ASSERT_NEXT(a_load_to_show, aclk, aresetn,
        state_reg == EM_LOAD, (state_reg == EM_SHOW) && valid_reg)

endmodule

// ===== src/framed_packet_parser.sv =====
// Channel   Direction  Payload
// s_        in         tdata[7:0] rx_byte
// m_        out        tdata: cmd, length, index, payload; tuser: status; tlast
// cfg_      in         addr[2:0] register index, data[7:0] value
//
// A received byte that does not close a frame is taken while the buffer is free.
// After the tail byte, each result of a payload run passes through a buffer read, an output load,
// then the handshake, set by the single read port; the next read waits until a result is taken.
// One byte may pass right after the tail; input then waits for the final result to load,
// and a tail byte waits until that result is taken.
// Reset is synchronous and active low, the buffer needs no clearing, and writes are always taken.
module framed_packet_parser #(
    parameter int MAX_PAYLOAD = fpp_pkg::FPP_MAX_PAYLOAD
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Received bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] frame_cmd, [13:8] frame_length,
                                   // [18:14] byte_index, [26:19] payload_byte
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_data
);

    localparam int AW = fpp_pkg::addr_width(MAX_PAYLOAD);

    logic                   byte_valid;
    logic                   at_tail;
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [7:0]             ram_wr_data;
    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;
    logic [7:0]             ram_rd_data;
    logic                   job_valid;
    fpp_pkg::job_t          job;
    fpp_pkg::emit_status_t  emit_status;
    fpp_pkg::status_t       res_status;
    logic [7:0]             res_cmd;
    logic [5:0]             res_length;
    logic [4:0]             res_index;
    logic [7:0]             res_payload;

    // A tail byte waits until the emitter can take a new frame.
    assign s_tready   = emit_status.ram_free && (!at_tail || emit_status.job_ready);
    assign byte_valid = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    fpp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .byte_valid  (byte_valid),
        .byte_data   (s_tdata),
        .at_tail     (at_tail),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .job_valid   (job_valid),
        .job         (job)
    );

    fpp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    fpp_emitter #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_emitter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (job_valid),
        .job         (job),
        .emit_status (emit_status),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_status  (res_status),
        .res_cmd     (res_cmd),
        .res_length  (res_length),
        .res_index   (res_index),
        .res_payload (res_payload),
        .res_last    (m_tlast)
    );

    // Pack the result fields from the lowest bit up.
    assign m_tdata = {5'd0, res_payload, res_index, res_length, res_cmd};
    assign m_tuser = res_status;

endmodule
